FILE: src/scpc_pkg.sv
// ----------------------------------------------------------------------------
// Signature and pattern coder package
// Shared types and codes for the coder and its divider.
// ----------------------------------------------------------------------------
package scpc_pkg;

  // Pattern codes carried on the result stream.
  localparam logic [1:0] PC_INVALID  = 2'd0;
  localparam logic [1:0] PC_DECREASE = 2'd1;
  localparam logic [1:0] PC_SAME     = 2'd2;
  localparam logic [1:0] PC_INCREASE = 2'd3;

  // Register index of the mode register.
  localparam logic REG_RELATIVE_MODE = 1'b0;

  // Status from the divider back to the sequencer.
  typedef struct packed {
    logic done;
    logic big;
  } div_status_t;

endpackage

FILE: src/signature_and_pattern_coder.sv
// ----------------------------------------------------------------------------
// Signature and pattern coder
// Emits the change between successive samples of a row, absolute or relative,
// with a direction code and saturation flag.
// ----------------------------------------------------------------------------
// Samples arrive one per transaction; each sample after the first of a row
// yields one result transaction. Absolute differences, missing samples and
// zero changes are handled in the accepting cycle and the next sample can be
// taken on the following cycle. In relative mode a nonzero change over a
// nonzero base goes through a restoring divider that produces one quotient
// bit per cycle. The block takes no new sample while such an item passes
// through S_DIV and S_FIN; its result is loaded into the output register in
// S_FIN and the block then returns to S_IDLE. The divider stops early when
// the quotient overflows.
// The input is not ready while the divider runs, while its result waits in
// S_FIN, or while a finished result is still waiting in the output register
// and the sink is stalling.
module signature_and_pattern_coder import scpc_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Sample stream. tdata: sample. tuser: bit 0 sample_is_nan, bit 1 row_start.
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,
  input  logic [1:0]                            s_tuser,
  input  logic                                  s_tlast,
  // Result stream. tdata: signature. tuser: bit 0 signature_valid,
  // bits 2:1 pattern_code, bit 3 saturated. tlast: last_of_row.
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_tdata,
  output logic [3:0]                            m_tuser,
  output logic                                  m_tlast,
  // Register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int W   = SAMPLE_WIDTH;
  localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_FIN  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic         relative_mode;
  logic [W-1:0] prev_sample;
  logic         prev_nan;
  logic         have_prev;

  logic         pend_neg;
  logic         pend_last;

  logic [W-1:0] signature;
  logic         signature_valid;
  logic [1:0]   pattern_code;
  logic         saturated;
  logic         last_of_row;

  // Accept-cycle datapath
  logic [W-1:0] cur;
  logic         cur_nan;
  logic         row_start;
  logic         accept;
  logic         produce;
  logic         valid;
  logic [W:0]   diff;
  logic         dneg;
  logic [W:0]   dmag;
  logic [W:0]   dmag_neg;
  logic         pneg;
  logic [W-1:0] pmag;
  logic         qneg;
  logic [W-1:0] div_limit;
  logic         div_start;
  logic         out_free;
  logic         load_now;

  logic [W-1:0] now_sig;
  logic [1:0]   now_code;
  logic         now_sat;

  div_status_t  div_stat;
  logic [W-1:0] quotient;
  logic [W-1:0] quot_neg;

  assign cur       = s_tdata[W-1:0];
  assign cur_nan   = s_tuser[0];
  assign row_start = s_tuser[1];

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    diff     = {cur[W-1], cur} - {prev_sample[W-1], prev_sample};
    dneg     = diff[W];
    dmag_neg = -diff;
    dmag     = dneg ? dmag_neg : diff;
    pneg     = prev_sample[W-1];
    pmag     = pneg ? -prev_sample : prev_sample;
    qneg     = dneg ^ pneg;
    div_limit = qneg ? SMIN : SMAX;
    produce  = !row_start && have_prev;
    valid    = !cur_nan && !prev_nan;

    now_sig   = '0;
    now_code  = PC_INVALID;
    now_sat   = 1'b0;
    div_start = 1'b0;
    if (!valid) begin
      now_code = PC_INVALID;
    end else if (dmag == '0) begin
      now_code = PC_SAME;
    end else if (!relative_mode) begin
      now_code = dneg ? PC_DECREASE : PC_INCREASE;
      if (dmag > {1'b0, (dneg ? SMIN : SMAX)}) begin
        now_sig = dneg ? SMIN : SMAX;
        now_sat = 1'b1;
      end else begin
        now_sig = diff[W-1:0];
      end
    end else if (pmag == '0) begin
      // A nonzero change over a zero base saturates with the change's sign.
      now_code = dneg ? PC_DECREASE : PC_INCREASE;
      now_sig  = dneg ? SMIN : SMAX;
      now_sat  = 1'b1;
    end else begin
      now_code  = qneg ? PC_DECREASE : PC_INCREASE;
      div_start = accept && produce;
    end
    load_now = accept && produce && !div_start;
  end

  scpc_div #(
    .W (W),
    .F (FRAC_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dmag),
    .divisor  (pmag),
    .limit    (div_limit),
    .status   (div_stat),
    .quotient (quotient)
  );

  assign quot_neg = -quotient;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (div_start) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      relative_mode <= 1'b1;
      prev_sample   <= '0;
      prev_nan      <= 1'b0;
      have_prev     <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      state <= state_next;
      if (psel && penable && pwrite && pready && paddr[2] == REG_RELATIVE_MODE) begin
        relative_mode <= pwdata[0];
      end
      if (accept) begin
        prev_sample <= cur;
        prev_nan    <= cur_nan;
        have_prev   <= !s_tlast;
      end
      if (load_now || (state == S_FIN && out_free)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      pend_neg  <= qneg;
      pend_last <= s_tlast;
    end
    if (load_now) begin
      signature       <= now_sig;
      signature_valid <= valid;
      pattern_code    <= now_code;
      saturated       <= now_sat;
      last_of_row     <= s_tlast;
    end else if (state == S_FIN && out_free) begin
      signature       <= pend_neg ? quot_neg : quotient;
      signature_valid <= 1'b1;
      pattern_code    <= pend_neg ? PC_DECREASE : PC_INCREASE;
      saturated       <= div_stat.big;
      last_of_row     <= pend_last;
    end
  end

  assign m_tdata = TDW'(signature);
  assign m_tuser = {saturated, pattern_code, signature_valid};
  assign m_tlast = last_of_row;

  assign prdata = {31'd0, relative_mode};
  assign pready = 1'b1;

`ifndef SYNTHESIS
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_sat_has_dir: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && saturated) |->
      (signature_valid && (pattern_code == PC_DECREASE || pattern_code == PC_INCREASE)))
    else $error("saturated result without a direction");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !signature_valid) |->
      (signature == '0 && pattern_code == PC_INVALID && !saturated))
    else $error("missing-sample result is not cleared");

  a_same_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && pattern_code == PC_SAME) |-> (signature == '0 && !saturated))
    else $error("no-change result carries a nonzero signature");

  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    div_start |=> state == S_DIV)
    else $error("division started without entering the divide state");
`endif

endmodule

FILE: src/scpc_div.sv
// ----------------------------------------------------------------------------
// Signature coder divider
// Radix-2 restoring divider for (dividend << F) / divisor, one quotient bit
// per cycle, stopping early once the quotient exceeds the limit.
// ----------------------------------------------------------------------------
module scpc_div import scpc_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [W:0]    dividend,
  input  logic [W-1:0]  divisor,
  input  logic [W-1:0]  limit,
  output div_status_t   status,
  output logic [W-1:0]  quotient
);

  localparam int NW = W + 1 + F;
  localparam int CW = $clog2(W + F + 1);

  logic          busy;
  logic          done;
  logic          big;
  logic [NW-1:0] num;
  logic [W-1:0]  rem;
  logic [W-1:0]  den;
  logic [W-1:0]  lim;
  logic [W:0]    q;
  logic [CW-1:0] cnt;

  logic [W:0]    rsh;
  logic [W:0]    rdiff;
  logic          fits;
  logic [W-1:0]  rem_next;
  logic [W:0]    q_next;
  logic          over;

  always_comb begin
    rsh      = {rem, num[NW-1]};
    rdiff    = rsh - {1'b0, den};
    fits     = rsh >= {1'b0, den};
    // The remainder stays below the divisor, so it always fits in W bits.
    rem_next = fits ? rdiff[W-1:0] : rsh[W-1:0];
    q_next   = {q[W-1:0], fits};
    over     = q_next > {1'b0, lim};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (over || cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= NW'(dividend) << F;
      rem <= '0;
      den <= divisor;
      lim <= limit;
      q   <= '0;
      big <= 1'b0;
      cnt <= CW'(W + F);
    end else if (busy) begin
      num <= num << 1;
      rem <= rem_next;
      q   <= q_next;
      cnt <= cnt - 1'b1;
      if (over) begin
        big <= 1'b1;
      end
    end
  end

  assign status.done = done;
  assign status.big  = big;
  assign quotient    = big ? lim : q[W-1:0];

endmodule
